// ----- rtl/core/lpd_pkg.sv -----
`default_nettype none
package lpd_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] ANGLE_TURN  = 16'hB400;

   // header is eight bytes, the last one closes it
   localparam int          HDR_BYTES   = 8;
   localparam logic [2:0]  HDR_LAST    = 3'(HDR_BYTES - 1);

   // sample is three bytes: intensity, distance low, distance high
   localparam logic [2:0]  SMP_INT     = 3'd0;
   localparam logic [2:0]  SMP_LOW     = 3'd1;
   localparam logic [2:0]  SMP_HIGH    = 3'd2;

   // restoring divider, one quotient bit per cycle
   localparam int          DIV_STEPS   = 16;
   localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic        KIND_SAMPLE = 1'b0;
   localparam logic        KIND_CLOUD  = 1'b1;

   typedef struct packed {
      logic       hdr_load;
      logic [2:0] hdr_pos;
      logic       hdr_finish;
      logic       div_step;
      logic       div_last;
      logic       hold_int;
      logic       hold_low;
      logic       sample;
   } lpd_cmd_type;

   typedef struct packed {
      logic sync_first;
      logic sync_second;
      logic cloud;
      logic count_zero;
      logic need_div;
      logic drop;
      logic last_sample;
      logic out_full;
      logic out_taken;
   } lpd_sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/lpd_req_if.sv -----
`default_nettype none
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lpd_rsp_if.sv -----
`default_nettype none
interface lpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  intensity;
   logic [15:0] distance_raw;
   logic [16:0] angle_raw;
   logic        new_scan;
   logic        last_in_packet;

   modport source (output valid, output kind, output intensity, output distance_raw,
                   output angle_raw, output new_scan, output last_in_packet,
                   input ready);
   modport sink (input valid, input kind, input intensity, input distance_raw,
                 input angle_raw, input new_scan, input last_in_packet,
                 output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lidar_packet_deframer_core.sv -----
// Latency: a result is valid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle, except that the last header byte of a packet whose
//   step needs a division is followed by a divider phase with req_chan.ready low,
//   in which the one-bit-per-cycle restoring divider finds the angle step; a byte that
//   completes a result also waits while rsp_chan.ready low holds the previous result.
// Reset: synchronous, active high; parser returns to sync hunt, previous angle clears.
`default_nettype none
module lidar_packet_deframer_core (
   input  wire logic clock,
   input  wire logic reset,
   lpd_req_if.sink   req_chan,
   lpd_rsp_if.source rsp_chan
);

   lpd_pkg::lpd_cmd_type cmd;
   lpd_pkg::lpd_sts_type sts;
   logic                 ready;

   lpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpd_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rx_byte (req_chan.rx_byte),
      .sts     (sts),
      .rsp     (rsp_chan)
   );

   assign req_chan.ready = ready;

endmodule
`default_nettype wire

// ----- rtl/core/lpd_dp.sv -----
`default_nettype none
module lpd_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lpd_pkg::lpd_cmd_type cmd,
   input  wire logic [7:0]           rx_byte,
   output lpd_pkg::lpd_sts_type      sts,
   lpd_rsp_if.source                 rsp
);

   logic        cloud_ff, cloud_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] end_ff, end_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] step_ff, step_in;
   logic [16:0] run_ff, run_in;
   logic [16:0] prev_ff, prev_in;
   logic [7:0]  int_ff, int_in;
   logic [7:0]  low_ff, low_in;
   logic        drop_ff, drop_in;
   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  dvsr_ff, dvsr_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_int_ff, out_int_in;
   logic [15:0] out_dist_ff, out_dist_in;
   logic [16:0] out_ang_ff, out_ang_in;
   logic        out_new_ff, out_new_in;
   logic        out_last_ff, out_last_in;

   logic [15:0] diff;
   logic        diff_gt1;
   logic [8:0]  rem_sh;
   logic        rem_ge;
   logic [8:0]  rem_sub;
   logic [15:0] quo_nx;
   logic        emit_cloud;
   logic        emit_sample;

   // angular span, wrapping at one turn
   always_comb begin
      if (end_ff < start_ff) begin
         diff = lpd_pkg::ANGLE_TURN - start_ff + end_ff;
      end else begin
         diff = end_ff - start_ff;
      end
   end
   assign diff_gt1 = (diff > 16'd1);

   // one restoring divide step
   assign rem_sh  = {rem_ff, quo_ff[15]};
   assign rem_ge  = (rem_sh >= {1'b0, dvsr_ff});
   assign rem_sub = rem_sh - {1'b0, dvsr_ff};
   assign quo_nx  = {quo_ff[14:0], rem_ge};

   assign emit_cloud  = cmd.hdr_finish && cloud_ff;
   assign emit_sample = cmd.sample && !drop_ff;

   always_comb begin
      cloud_in = cloud_ff;
      count_in = count_ff;
      start_in = start_ff;
      end_in   = end_ff;
      left_in  = left_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      prev_in  = prev_ff;
      int_in   = int_ff;
      low_in   = low_ff;
      drop_in  = drop_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvsr_in  = dvsr_ff;

      if (cmd.hdr_load) begin
         case (cmd.hdr_pos)
            3'd0: cloud_in = rx_byte[0];
            3'd1: count_in = rx_byte;
            3'd2: start_in = {start_ff[15:8], rx_byte};
            3'd3: start_in = {rx_byte, start_ff[7:0]};
            3'd4: end_in   = {end_ff[15:8], rx_byte};
            3'd5: end_in   = {rx_byte, end_ff[7:0]};
            default: ;
         endcase
      end

      if (cmd.hdr_finish) begin
         drop_in = diff_gt1 && (count_ff < 8'd2);
         step_in = '0;
         run_in  = {1'b0, start_ff};
         left_in = count_ff;
         rem_in  = '0;
         quo_in  = diff;
         dvsr_in = count_ff - 8'd1;
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[7:0] : rem_sh[7:0];
         quo_in = quo_nx;
         if (cmd.div_last) begin
            step_in = quo_nx;
         end
      end

      if (cmd.hold_int) begin
         int_in = rx_byte;
      end
      if (cmd.hold_low) begin
         low_in = rx_byte;
      end

      if (cmd.sample) begin
         left_in = left_ff - 8'd1;
         if (!drop_ff) begin
            prev_in = run_ff;
            run_in  = run_ff + {1'b0, step_ff};
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_int_in   = out_int_ff;
      out_dist_in  = out_dist_ff;
      out_ang_in   = out_ang_ff;
      out_new_in   = out_new_ff;
      out_last_in  = out_last_ff;
      if (emit_cloud) begin
         out_valid_in = 1'b1;
         out_kind_in  = lpd_pkg::KIND_CLOUD;
         out_int_in   = '0;
         out_dist_in  = '0;
         out_ang_in   = '0;
         out_new_in   = 1'b0;
         out_last_in  = 1'b0;
      end else if (emit_sample) begin
         out_valid_in = 1'b1;
         out_kind_in  = lpd_pkg::KIND_SAMPLE;
         out_int_in   = int_ff;
         out_dist_in  = {rx_byte, low_ff};
         out_ang_in   = run_ff;
         out_new_in   = (run_ff < prev_ff);
         out_last_in  = (left_ff == 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cloud_ff     <= 1'b0;
         count_ff     <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         left_ff      <= '0;
         step_ff      <= '0;
         run_ff       <= '0;
         prev_ff      <= '0;
         int_ff       <= '0;
         low_ff       <= '0;
         drop_ff      <= 1'b0;
         rem_ff       <= '0;
         quo_ff       <= '0;
         dvsr_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cloud_ff     <= cloud_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         left_ff      <= left_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         prev_ff      <= prev_in;
         int_ff       <= int_in;
         low_ff       <= low_in;
         drop_ff      <= drop_in;
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
         dvsr_ff      <= dvsr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_int_ff  <= out_int_in;
      out_dist_ff <= out_dist_in;
      out_ang_ff  <= out_ang_in;
      out_new_ff  <= out_new_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_kind_ff;
   assign rsp.intensity      = out_int_ff;
   assign rsp.distance_raw   = out_dist_ff;
   assign rsp.angle_raw      = out_ang_ff;
   assign rsp.new_scan       = out_new_ff;
   assign rsp.last_in_packet = out_last_ff;

   assign sts.sync_first  = (rx_byte == lpd_pkg::SYNC_FIRST);
   assign sts.sync_second = (rx_byte == lpd_pkg::SYNC_SECOND);
   assign sts.cloud       = cloud_ff;
   assign sts.count_zero  = (count_ff == 8'd0);
   assign sts.need_div    = diff_gt1 && (count_ff >= 8'd2);
   assign sts.drop        = drop_ff;
   assign sts.last_sample = (left_ff == 8'd1);
   assign sts.out_full    = out_valid_ff;
   assign sts.out_taken   = rsp.ready;

endmodule
`default_nettype wire

// ----- rtl/core/lpd_ctrl.sv -----
`default_nettype none
module lpd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lpd_pkg::lpd_sts_type sts,
   output lpd_pkg::lpd_cmd_type      cmd
);

   localparam logic [2:0] ST_HUNT0 = 3'd0;
   localparam logic [2:0] ST_HUNT1 = 3'd1;
   localparam logic [2:0] ST_HEAD  = 3'd2;
   localparam logic [2:0] ST_DATA  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [2:0]                    pos_ff, pos_in;
   logic [lpd_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic will_emit;
   logic accept;

   // a byte that produces a result needs a free (or draining) output register
   assign will_emit = ((state_ff == ST_HEAD) && (pos_ff == lpd_pkg::HDR_LAST) && sts.cloud) ||
                      ((state_ff == ST_DATA) && (pos_ff == lpd_pkg::SMP_HIGH) && !sts.drop);
   assign req_ready = (state_ff != ST_DIV) &&
                      (!will_emit || !sts.out_full || sts.out_taken);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.hdr_pos = pos_ff;

      case (state_ff)
         ST_HUNT1: begin
            if (accept) begin
               pos_in   = '0;
               state_in = sts.sync_second ? ST_HEAD : ST_HUNT0;
            end
         end
         ST_HEAD: begin
            if (accept) begin
               cmd.hdr_load = 1'b1;
               if (pos_ff == lpd_pkg::HDR_LAST) begin
                  cmd.hdr_finish = 1'b1;
                  pos_in         = '0;
                  div_cnt_in     = '0;
                  if (sts.count_zero) begin
                     state_in = ST_HUNT0;
                  end else if (sts.need_div) begin
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_DATA;
                  end
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + lpd_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == lpd_pkg::DIV_LAST) begin
               cmd.div_last = 1'b1;
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               case (pos_ff)
                  lpd_pkg::SMP_INT: begin
                     cmd.hold_int = 1'b1;
                     pos_in       = lpd_pkg::SMP_LOW;
                  end
                  lpd_pkg::SMP_LOW: begin
                     cmd.hold_low = 1'b1;
                     pos_in       = lpd_pkg::SMP_HIGH;
                  end
                  default: begin
                     cmd.sample = 1'b1;
                     pos_in     = lpd_pkg::SMP_INT;
                     if (sts.last_sample) begin
                        state_in = ST_HUNT0;
                     end
                  end
               endcase
            end
         end
         default: begin
            // first sync byte hunt; unused codes fall back here too
            if (accept) begin
               state_in = sts.sync_first ? ST_HUNT1 : ST_HUNT0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_HUNT0;
         pos_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   a_div_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !req_ready)
      else $error("input taken while divider runs");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == lpd_pkg::DIV_LAST) |=> (state_ff == ST_DATA))
      else $error("divider did not hand over to sample phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && will_emit) |-> (!sts.out_full || sts.out_taken))
      else $error("pending result overwritten");

   a_data_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (pos_ff < 3'd3))
      else $error("sample byte position out of range");

endmodule
`default_nettype wire
